/* src/mrw_pkg.sv */
// ============================================================================
// mrw_pkg: shared types and constants for the run window checker
// Widths, through masks, the window cell record, result record and helpers.
// ============================================================================
package mrw_pkg;

	// Depth of the window chain; the longest window is RING_DEPTH + 1 cells.
	localparam int RING_DEPTH  = 64;
	localparam int RUN_BITS    = 7;
	localparam int DOMAIN_BITS = 16;
	localparam int INDEX_BITS  = 12;
	localparam int S_TDATA_BITS = 32;
	localparam int M_TDATA_BITS = 32;

	localparam logic [RUN_BITS-1:0]    RUN_RESET = 7'd3;
	localparam logic [DOMAIN_BITS-1:0] THROUGH_H = 16'hCC00;
	localparam logic [DOMAIN_BITS-1:0] THROUGH_V = 16'hA0A0;

	typedef enum logic {
		KIND_BAN    = 1'b0,
		KIND_CONTRA = 1'b1
	} kind_t;

	// One window cell: its through bits, its index and its classification.
	typedef struct packed {
		logic [DOMAIN_BITS-1:0] thr;
		logic [INDEX_BITS-1:0]  idx;
		logic                   can;
		logic                   must;
	} cell_entry_t;

	typedef struct packed {
		kind_t                  kind;
		logic [INDEX_BITS-1:0]  target_cell;
		logic [DOMAIN_BITS-1:0] ban_mask;
	} result_t;

	function automatic logic [DOMAIN_BITS-1:0] through_mask(input logic vert);
		return vert ? THROUGH_V : THROUGH_H;
	endfunction

	// Clamp the register value into the supported run range.
	function automatic logic [RUN_BITS-1:0] eff_run(input logic [RUN_BITS-1:0] raw);
		if (raw == '0) begin
			return RUN_BITS'(1);
		end
		if (raw > RUN_BITS'(RING_DEPTH)) begin
			return RUN_BITS'(RING_DEPTH);
		end
		return raw;
	endfunction

	// One-hot select of the chain cell where a new item enters, so that it
	// reaches the last cell after run - 1 further shifts.
	function automatic logic [RING_DEPTH-1:0] entry_onehot(input logic [RUN_BITS-1:0] run);
		logic [RING_DEPTH-1:0] sel;
		sel = '0;
		for (int k = 0; k < RING_DEPTH; k++) begin
			if (RUN_BITS'(RING_DEPTH - k) == run) begin
				sel[k] = 1'b1;
			end
		end
		return sel;
	endfunction

endpackage

/* src/mrw_cell.sv */
// ============================================================================
// mrw_cell: one stage of the window chain
// Holds one cell record; on a shift it takes either its neighbor's record or,
// when it is the entry point, the new item.
// ============================================================================
module mrw_cell (
	input  logic                clk,
	input  logic                shift_en,
	input  logic                load_sel,
	input  mrw_pkg::cell_entry_t new_entry,
	input  mrw_pkg::cell_entry_t prev_entry,
	output mrw_pkg::cell_entry_t entry_q
);

	always_ff @(posedge clk) begin
		if (shift_en) begin
			entry_q <= load_sel ? new_entry : prev_entry;
		end
	end

endmodule

/* src/mrw_out_fifo.sv */
// ============================================================================
// mrw_out_fifo: two-entry output buffer
// An output register plus a skid register, so a new result can be taken
// while the previous one still waits on the output.
// ============================================================================
module mrw_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mrw_pkg::result_t push_data,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output mrw_pkg::result_t out_data
);

	logic             out_v_q;
	logic             skid_v_q;
	mrw_pkg::result_t out_q;
	mrw_pkg::result_t skid_q;
	logic             pop;

	assign pop       = out_v_q & out_ready;
	assign room      = ~skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (out_v_q && !pop) begin
				if (push) begin
					skid_v_q <= 1'b1;
				end
			end else if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= push;
			end else begin
				out_v_q <= push;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && !pop) begin
			if (push) begin
				skid_q <= push_data;
			end
		end else if (skid_v_q) begin
			out_q <= skid_q;
			if (push) begin
				skid_q <= push_data;
			end
		end else if (push) begin
			out_q <= push_data;
		end
	end

	// The skid slot is only ever filled behind a waiting output.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry valid while output register empty");

	// A result is never offered when both slots are taken.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("result pushed into full output buffer");

endmodule

/* src/max_run_window_ban_checker.sv */
// ============================================================================
// max_run_window_ban_checker: sliding window check on runs of through tiles
// Streams the cells of grid lines and reports ban requests or contradictions.
// ============================================================================
// The block takes one cell request per clock cycle while s_tready is high and
// answers it with zero or one registered result. Each cell of a line
// is classified against the line's through mask (0xCC00 for rows, 0xA0A0 for
// columns, latched from the first cell of the window): it can be a through
// tile when its domain meets the mask, and must be one when nothing outside
// the mask is left. Running counts over the last max_run + 1 cells are kept
// and updated by adding the new cell and dropping the oldest one. The oldest
// cell comes from a chain of 64 cells: a new cell enters at the stage that
// is max_run stages from the end, so the last stage always holds the cell
// that leaves the window. When a full window holds only forced cells a
// contradiction (tuser 1) names the window's first cell and the rest of the
// pass is ignored until a cell with pass_first. When exactly one cell is
// flexible, a ban request (tuser 0) gives that cell and its through bits.
// Results sit in a two-entry output buffer; s_tready drops only while both
// entries are held. Writing max_run clears the window and should be done while
// the block is idle; values of 0 act as 1 and values above 64 act as 64.
module max_run_window_ban_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration: max_run.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mrw_pkg::RUN_BITS-1:0]        cfg_data,
	// Cell requests.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [15:0] domain, [27:16] cell_index, [31:28] zero
	input  logic [mrw_pkg::S_TDATA_BITS-1:0]    s_tdata,
	// [0] vertical, [1] pass_first
	input  logic [1:0]                          s_tuser,
	input  logic                                s_tlast,
	// Results.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [11:0] target_cell, [27:12] ban_mask, [31:28] zero
	output logic [mrw_pkg::M_TDATA_BITS-1:0]    m_tdata,
	// [0] kind
	output logic                                m_tuser
);

	localparam int RB = mrw_pkg::RUN_BITS;
	localparam int DB = mrw_pkg::DOMAIN_BITS;
	localparam int IB = mrw_pkg::INDEX_BITS;
	localparam int RD = mrw_pkg::RING_DEPTH;

	// Configuration and window state.
	logic [RB-1:0] run_q;
	logic [RD-1:0] entry_sel_q;
	logic [RB-1:0] fill_q;
	logic [RB-1:0] poss_q;
	logic [RB-1:0] forc_q;
	logic [IB-1:0] sum_q;
	logic [DB-1:0] xor_q;
	logic          line_vert_q;
	logic          failed_q;

	// Input fields.
	logic [DB-1:0] domain;
	logic [IB-1:0] cell_index;
	logic          vertical;
	logic          pass_first;
	logic          line_last;

	assign domain     = s_tdata[DB-1:0];
	assign cell_index = s_tdata[DB+IB-1:DB];
	assign vertical   = s_tuser[0];
	assign pass_first = s_tuser[1];
	assign line_last  = s_tlast;

	logic acc;
	logic cfg_wr;
	logic room;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign s_tready  = room;
	assign acc       = s_tvalid & s_tready;

	// Window chain.
	mrw_pkg::cell_entry_t cell_q [RD];
	mrw_pkg::cell_entry_t new_entry;
	mrw_pkg::cell_entry_t old_entry;
	logic                 shift_en;

	assign old_entry = cell_q[RD-1];

	for (genvar k = 0; k < RD; k++) begin : g_chain
		mrw_pkg::cell_entry_t prev;
		if (k == 0) begin : g_head
			assign prev = new_entry;
		end else begin : g_body
			assign prev = cell_q[k-1];
		end
		mrw_cell u_cell (
			.clk       (clk),
			.shift_en  (shift_en),
			.load_sel  (entry_sel_q[k]),
			.new_entry (new_entry),
			.prev_entry(prev),
			.entry_q   (cell_q[k])
		);
	end

	// Update of the running counts for one accepted cell.
	logic          fail_c;
	logic [RB-1:0] fill_c, poss_c, forc_c;
	logic [IB-1:0] sum_c;
	logic [DB-1:0] xor_c;
	logic          vert_c;
	logic [DB-1:0] through;
	logic          new_flex, old_flex;
	logic [RB-1:0] p1, f1;
	logic [IB-1:0] s1;
	logic [DB-1:0] x1;
	logic [RB-1:0] wlen;
	logic          full, all_can, contra, ban;
	logic [RB-1:0] fill_n, poss_n, forc_n;
	logic [IB-1:0] sum_n;
	logic [DB-1:0] xor_n;
	logic          vert_n, failed_n;
	mrw_pkg::result_t res;

	always_comb begin
		// A pass start clears the sticky failure and the window first.
		fail_c = pass_first ? 1'b0 : failed_q;
		fill_c = pass_first ? '0 : fill_q;
		poss_c = pass_first ? '0 : poss_q;
		forc_c = pass_first ? '0 : forc_q;
		sum_c  = pass_first ? '0 : sum_q;
		xor_c  = pass_first ? '0 : xor_q;

		vert_c  = (fill_c == '0) ? vertical : line_vert_q;
		through = mrw_pkg::through_mask(vert_c);

		new_entry.thr  = domain & through;
		new_entry.idx  = cell_index;
		new_entry.can  = |new_entry.thr;
		new_entry.must = new_entry.can & ~|(domain & ~through);
		new_flex = new_entry.can & ~new_entry.must;
		old_flex = old_entry.can & ~old_entry.must;

		p1 = poss_c + {{(RB-1){1'b0}}, new_entry.can};
		f1 = forc_c + {{(RB-1){1'b0}}, new_entry.must};
		s1 = sum_c + (new_flex ? new_entry.idx : '0);
		x1 = xor_c ^ (new_flex ? new_entry.thr : '0);

		wlen    = run_q + RB'(1);
		full    = fill_c >= run_q;
		all_can = full & (p1 == wlen);
		contra  = ~fail_c & all_can & (f1 == wlen);
		ban     = ~fail_c & all_can & (f1 != wlen) & (f1 == run_q);

		shift_en = acc & ~fail_c & ~contra;

		fill_n   = fill_c;
		poss_n   = poss_c;
		forc_n   = forc_c;
		sum_n    = sum_c;
		xor_n    = xor_c;
		vert_n   = line_vert_q;
		failed_n = fail_c | contra;

		if (!fail_c) begin
			vert_n = vert_c;
			if (contra) begin
				fill_n = '0;
				poss_n = '0;
				forc_n = '0;
				sum_n  = '0;
				xor_n  = '0;
			end else if (full) begin
				// Drop the cell that leaves the window.
				poss_n = p1 - {{(RB-1){1'b0}}, old_entry.can};
				forc_n = f1 - {{(RB-1){1'b0}}, old_entry.must};
				sum_n  = s1 - (old_flex ? old_entry.idx : '0);
				xor_n  = x1 ^ (old_flex ? old_entry.thr : '0);
			end else begin
				fill_n = fill_c + RB'(1);
				poss_n = p1;
				forc_n = f1;
				sum_n  = s1;
				xor_n  = x1;
			end
		end

		// The window never spans two lines.
		if (line_last) begin
			fill_n = '0;
			poss_n = '0;
			forc_n = '0;
			sum_n  = '0;
			xor_n  = '0;
		end

		res.kind        = contra ? mrw_pkg::KIND_CONTRA : mrw_pkg::KIND_BAN;
		res.target_cell = contra ? old_entry.idx : s1;
		res.ban_mask    = contra ? '0 : x1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= mrw_pkg::RUN_RESET;
			entry_sel_q <= mrw_pkg::entry_onehot(mrw_pkg::RUN_RESET);
			fill_q      <= '0;
			poss_q      <= '0;
			forc_q      <= '0;
			sum_q       <= '0;
			xor_q       <= '0;
			line_vert_q <= 1'b0;
			failed_q    <= 1'b0;
		end else begin
			if (acc) begin
				fill_q      <= fill_n;
				poss_q      <= poss_n;
				forc_q      <= forc_n;
				sum_q       <= sum_n;
				xor_q       <= xor_n;
				line_vert_q <= vert_n;
				failed_q    <= failed_n;
			end
			// A new run length restarts the window.
			if (cfg_wr) begin
				run_q       <= mrw_pkg::eff_run(cfg_data);
				entry_sel_q <= mrw_pkg::entry_onehot(mrw_pkg::eff_run(cfg_data));
				fill_q      <= '0;
				poss_q      <= '0;
				forc_q      <= '0;
				sum_q       <= '0;
				xor_q       <= '0;
			end
		end
	end

	// Output buffer.
	mrw_pkg::result_t out_res;

	mrw_out_fifo u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (acc & (contra | ban)),
		.push_data(res),
		.room     (room),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (out_res)
	);

	assign m_tuser = out_res.kind;
	assign m_tdata = {{(mrw_pkg::M_TDATA_BITS - IB - DB){1'b0}}, out_res.ban_mask,
		out_res.target_cell};

	// The fill level never passes the window's stored part.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= run_q)
		else $error("window fill exceeds run length");

	// Forced cells are a subset of possible ones.
	a_forced_le_possible: assert property (@(posedge clk) disable iff (!arst_n)
		forc_q <= poss_q)
		else $error("forced count above possible count");

	// A reported contradiction leaves the pass failed and the chain unshifted.
	a_contra_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && contra) |=> (failed_q && fill_q == '0))
		else $error("contradiction did not set the failure flag");

	a_entry_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(entry_sel_q))
		else $error("chain entry select not one-hot");

endmodule

/* bench/max_run_window_ban_checker_tb.sv */
// ============================================================================
// max_run_window_ban_checker_tb: self-checking bench for the run window checker
// Streams grid lines of cells into the block and predicts every ban request
// and contradiction with an independent window model. Each result is compared
// field by field. Directed lines, register extremes, output back-pressure and
// a long random phase with idling on both streams are covered.
// ============================================================================
module max_run_window_ban_checker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH    = mrw_pkg::RING_DEPTH;
	localparam int RUN_BITS      = mrw_pkg::RUN_BITS;
	localparam int DOMAIN_BITS   = mrw_pkg::DOMAIN_BITS;
	localparam int INDEX_BITS    = mrw_pkg::INDEX_BITS;
	localparam int S_TDATA_BITS  = mrw_pkg::S_TDATA_BITS;
	localparam int M_TDATA_BITS  = mrw_pkg::M_TDATA_BITS;

	localparam int TIMEOUT_NS    = 1_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_IDLE      = 13;
	localparam int REPORT_LIMIT  = 10;
	// Cells sent by the random phase; the directed tests add about 220 more.
	localparam int RANDOM_CELLS  = 730;
	localparam int PAD_BITS      = S_TDATA_BITS - INDEX_BITS - DOMAIN_BITS;

	// How a generated cell relates to the line's through mask.
	typedef enum {
		CELL_FORCED,
		CELL_FLEX,
		CELL_BLOCKED
	} cell_class_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [RUN_BITS-1:0]     cfg_data  = '0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [S_TDATA_BITS-1:0] s_tdata   = '0;   // [15:0] domain, [27:16] cell_index, [31:28] zero
	logic [1:0]              s_tuser   = '0;   // [0] vertical, [1] pass_first
	logic                    s_tlast   = 1'b0;
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	logic [M_TDATA_BITS-1:0] m_tdata;          // [11:0] target_cell, [27:12] ban_mask, [31:28] zero
	logic                    m_tuser;          // [0] kind

	max_run_window_ban_checker u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Window model. It mirrors the block's architectural state: the register,
	// a ring of the last cells of the line, the running counts and the sticky
	// failure flag of the current pass.
	// ------------------------------------------------------------------------
	logic [RUN_BITS-1:0]            run_reg      = mrw_pkg::RUN_RESET;
	logic [DOMAIN_BITS-1:0]         ring_dom [RING_DEPTH];
	logic [INDEX_BITS-1:0]          ring_idx [RING_DEPTH];
	logic [$clog2(RING_DEPTH)-1:0]  ring_head    = '0;
	logic [6:0]                     fill_cnt     = '0;
	logic [6:0]                     can_cnt      = '0;
	logic [6:0]                     must_cnt     = '0;
	logic [17:0]                    flex_idx_sum = '0;
	logic [DOMAIN_BITS-1:0]         flex_dom_xor = '0;
	logic                           line_vert    = 1'b0;
	logic                           pass_failed  = 1'b0;

	// Ban requests and contradictions still owed by the block, oldest first.
	mrw_pkg::result_t pending_results[$];
	int               n_fail  = 0;
	int               n_cells = 0;

	// Idling controls shared between the tests and the two stream processes.
	bit tx_idle_on     = 1'b0;
	bit rx_idle_on     = 1'b0;
	int rx_hold_len    = 0;
	int rx_holds_asked = 0;
	int rx_holds_done  = 0;
	int rx_wait        = 0;

	function automatic void report_failure(input string msg);
		n_fail++;
		if (n_fail <= REPORT_LIMIT) begin
			$display("[%0t] error: %s", $realtime, msg);
		end
	endfunction

	// Register values of 0 behave as 1, values above the ring depth as the depth.
	function automatic int effective_run(input logic [RUN_BITS-1:0] raw);
		return (raw == '0) ? 1 : (int'(raw) > RING_DEPTH) ? RING_DEPTH : int'(raw);
	endfunction

	function automatic void empty_window();
		fill_cnt     = '0;
		can_cnt      = '0;
		must_cnt     = '0;
		flex_idx_sum = '0;
		flex_dom_xor = '0;
	endfunction

	// Adds a cell to the counts, or takes it out again when it leaves the window.
	function automatic void tally(input logic [DOMAIN_BITS-1:0] dom,
			input logic [INDEX_BITS-1:0] idx, input logic [DOMAIN_BITS-1:0] thr,
			input bit drop);
		logic can_thru;
		logic must_thru;
		can_thru  = (dom & thr) != '0;
		must_thru = can_thru && ((dom & ~thr) == '0);
		if (drop) begin
			can_cnt  = can_cnt - 7'(can_thru);
			must_cnt = must_cnt - 7'(must_thru);
			if (can_thru && !must_thru) begin
				flex_idx_sum = flex_idx_sum - 18'(idx);
			end
		end else begin
			can_cnt  = can_cnt + 7'(can_thru);
			must_cnt = must_cnt + 7'(must_thru);
			if (can_thru && !must_thru) begin
				flex_idx_sum = flex_idx_sum + 18'(idx);
			end
		end
		if (can_thru && !must_thru) begin
			flex_dom_xor = flex_dom_xor ^ dom;
		end
	endfunction

	function automatic void store_cell(input logic [DOMAIN_BITS-1:0] dom,
			input logic [INDEX_BITS-1:0] idx);
		ring_dom[ring_head] = dom;
		ring_idx[ring_head] = idx;
		ring_head = ring_head + 1'b1;
	endfunction

	// Works out what one accepted cell causes and queues the expected result.
	function automatic void predict_cell(input logic [DOMAIN_BITS-1:0] dom,
			input logic [INDEX_BITS-1:0] idx, input logic vert, input logic last,
			input logic first);
		int                            run;
		logic [6:0]                    wlen;
		logic [DOMAIN_BITS-1:0]        thr;
		logic [$clog2(RING_DEPTH)-1:0] slot;
		mrw_pkg::result_t              res;
		n_cells++;
		if (first) begin
			pass_failed = 1'b0;
			empty_window();
		end
		if (!pass_failed) begin
			run  = effective_run(run_reg);
			wlen = 7'(run + 1);
			// The orientation is latched from the first cell of the window.
			if (fill_cnt == '0) begin
				line_vert = vert;
			end
			thr = line_vert ? mrw_pkg::THROUGH_V : mrw_pkg::THROUGH_H;
			tally(dom, idx, thr, 1'b0);
			if (int'(fill_cnt) >= run) begin
				// Oldest cell of the full window; a run of 64 wraps onto the head.
				slot = ring_head - $clog2(RING_DEPTH)'(run);
				if (can_cnt == wlen && must_cnt == wlen) begin
					res.kind        = mrw_pkg::KIND_CONTRA;
					res.target_cell = ring_idx[slot];
					res.ban_mask    = '0;
					pending_results.push_back(res);
					pass_failed = 1'b1;
					empty_window();
				end else begin
					if (can_cnt == wlen && must_cnt == wlen - 7'd1) begin
						// Only one flexible cell: the sums hold exactly that cell.
						res.kind        = mrw_pkg::KIND_BAN;
						res.target_cell = flex_idx_sum[INDEX_BITS-1:0];
						res.ban_mask    = flex_dom_xor & thr;
						pending_results.push_back(res);
					end
					tally(ring_dom[slot], ring_idx[slot], thr, 1'b1);
					store_cell(dom, idx);
				end
			end else begin
				store_cell(dom, idx);
				fill_cnt = fill_cnt + 7'd1;
			end
		end
		if (last) begin
			empty_window();
		end
	endfunction

	// ------------------------------------------------------------------------
	// Monitor and checker. All handshakes are sampled on the rising edge with
	// the values that held before it. A result seen at an edge always belongs
	// to a request accepted at an earlier edge, so checking comes first.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : stream_monitor
		mrw_pkg::result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_failure($sformatf("unexpected result kind %0d cell %0d mask %h",
						m_tuser, m_tdata[INDEX_BITS-1:0], m_tdata[INDEX_BITS +: DOMAIN_BITS]));
				end else begin
					want = pending_results.pop_front();
					if (m_tuser !== want.kind
							|| m_tdata[INDEX_BITS-1:0] !== want.target_cell
							|| m_tdata[INDEX_BITS +: DOMAIN_BITS] !== want.ban_mask) begin
						report_failure($sformatf(
							"expected kind %0d cell %0d mask %h, got kind %0d cell %0d mask %h",
							want.kind, want.target_cell, want.ban_mask, m_tuser,
							m_tdata[INDEX_BITS-1:0], m_tdata[INDEX_BITS +: DOMAIN_BITS]));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				run_reg = cfg_data;
				empty_window();
			end
			if (s_tvalid && s_tready) begin
				predict_cell(s_tdata[DOMAIN_BITS-1:0], s_tdata[DOMAIN_BITS +: INDEX_BITS],
					s_tuser[0], s_tlast, s_tuser[1]);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result sink. After each accepted result it may stall for a random number
	// of cycles. A long hold-off asked by a test is counted here as well, and
	// keeps tready low while the sender carries on.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_sink
		int gap;
		if (arst_n) begin
			if (rx_holds_done != rx_holds_asked) begin
				rx_holds_done <= rx_holds_asked;
				m_tready      <= 1'b0;
				rx_wait       <= rx_hold_len;
			end else if (m_tvalid && m_tready) begin
				gap = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
				m_tready <= (gap == 0);
				rx_wait  <= gap;
			end else if (rx_wait > 0) begin
				rx_wait  <= rx_wait - 1;
				m_tready <= (rx_wait == 1);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Shared stimulus helpers.
	// ------------------------------------------------------------------------

	// Offers one cell request and returns at the edge where it is accepted.
	// Valid is only lowered when a gap is drawn, so back-to-back requests keep
	// it high without a lower-and-raise in the same step.
	task automatic send_cell(input logic [DOMAIN_BITS-1:0] dom,
			input logic [INDEX_BITS-1:0] idx, input logic vert, input logic last,
			input logic first);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{PAD_BITS{1'b0}}, idx, dom};
		s_tuser  <= {first, vert};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Stops sending and waits until every owed result has come, then lets the
	// block settle in case the last cells were still in flight without result.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_max_run(input logic [RUN_BITS-1:0] value);
		wait_for_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic cell_class_t pick_class(input int pct_forced, input int pct_flex);
		int r;
		r = $urandom_range(0, 99);
		if (r < pct_forced) begin
			return CELL_FORCED;
		end
		return (r < pct_forced + pct_flex) ? CELL_FLEX : CELL_BLOCKED;
	endfunction

	function automatic logic [DOMAIN_BITS-1:0] make_domain(input cell_class_t cls,
			input logic [DOMAIN_BITS-1:0] thr);
		logic [DOMAIN_BITS-1:0] inner;
		logic [DOMAIN_BITS-1:0] outer;
		inner = DOMAIN_BITS'($urandom) & thr;
		outer = DOMAIN_BITS'($urandom) & ~thr;
		if (inner == '0) begin
			inner = thr;
		end
		if (outer == '0) begin
			outer = ~thr;
		end
		unique case (cls)
			CELL_FORCED: begin
				return inner;
			end
			CELL_FLEX: begin
				return inner | outer;
			end
			default: begin
				return outer;
			end
		endcase
	endfunction

	// Sends one line of cells with random content. Cells after the first carry
	// a random orientation bit, which the block must ignore. A line that is not
	// closed leaves its window open into the next line.
	task automatic send_line(input int len, input bit opens_pass, input bit closed,
			input int pct_forced, input int pct_flex);
		logic                   vert;
		logic [DOMAIN_BITS-1:0] thr;
		logic [INDEX_BITS-1:0]  idx;
		vert = 1'($urandom);
		thr  = vert ? mrw_pkg::THROUGH_V : mrw_pkg::THROUGH_H;
		idx  = INDEX_BITS'($urandom);
		for (int k = 0; k < len; k++) begin
			send_cell(make_domain(pick_class(pct_forced, pct_flex), thr), idx,
				(k == 0) ? vert : 1'($urandom), closed && (k == len - 1),
				opens_pass && (k == 0));
			idx = ($urandom_range(0, 3) == 0) ? INDEX_BITS'($urandom) : idx + 1'b1;
		end
	endtask

	// Cells with fully random fields, line and pass marks included.
	task automatic send_noise(input int count);
		for (int k = 0; k < count; k++) begin
			send_cell(DOMAIN_BITS'($urandom_range(1, 65535)), INDEX_BITS'($urandom),
				1'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 15) == 0);
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------------

	// Runs at the reset value of max_run (3, a window of four cells).
	task automatic test_directed_cases();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b1;
		// Row pass: one flexible cell with every candidate set among forced ones
		// gives a ban, then again when the window slides by one.
		send_cell(16'hCC00, 12'd0,    1'b0, 1'b0, 1'b1);
		send_cell(16'hFFFF, 12'd4095, 1'b1, 1'b0, 1'b0);
		send_cell(16'h0400, 12'd5,    1'b0, 1'b0, 1'b0);
		send_cell(16'h8000, 12'd6,    1'b0, 1'b0, 1'b0);
		send_cell(16'h4000, 12'd7,    1'b0, 1'b1, 1'b0);
		// Column line whose middle cells claim to be rows: the mask stays the
		// column one, all four are forced, and the contradiction names cell 100.
		send_cell(16'h0020, 12'd100,  1'b1, 1'b0, 1'b0);
		send_cell(16'hA0A0, 12'd101,  1'b0, 1'b0, 1'b0);
		send_cell(16'h8000, 12'd102,  1'b0, 1'b0, 1'b0);
		send_cell(16'h0080, 12'd103,  1'b1, 1'b0, 1'b0);
		// The rest of the failed pass is ignored, line end included.
		send_cell(16'h8000, 12'd104,  1'b1, 1'b0, 1'b0);
		send_cell(16'hFFFF, 12'd105,  1'b1, 1'b1, 1'b0);
		// New pass with a line shorter than the window: nothing comes out.
		send_cell(16'h0001, 12'd200,  1'b0, 1'b0, 1'b1);
		send_cell(16'h0800, 12'd201,  1'b0, 1'b0, 1'b0);
		send_cell(16'h0C00, 12'd202,  1'b0, 1'b1, 1'b0);
		// A cell that cannot be through breaks every window it sits in.
		send_cell(16'hCC00, 12'd300,  1'b0, 1'b0, 1'b0);
		send_cell(16'h4400, 12'd301,  1'b0, 1'b0, 1'b0);
		send_cell(16'h3301, 12'd302,  1'b0, 1'b0, 1'b0);
		send_cell(16'h8800, 12'd303,  1'b0, 1'b0, 1'b0);
		send_cell(16'h0400, 12'd304,  1'b0, 1'b1, 1'b0);
		// Two flexible cells in one window give no ban either.
		send_cell(16'h8001, 12'd310,  1'b0, 1'b0, 1'b0);
		send_cell(16'h4002, 12'd311,  1'b0, 1'b0, 1'b0);
		send_cell(16'h8000, 12'd312,  1'b0, 1'b0, 1'b0);
		send_cell(16'h0800, 12'd313,  1'b0, 1'b1, 1'b0);
		wait_for_results();
	endtask

	// Register extremes, and the window clear that a register write causes.
	task automatic test_register_extremes();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b0;
		// Zero acts as a run of one: windows of two cells.
		set_max_run(7'd0);
		send_cell(16'h0400, 12'd10, 1'b0, 1'b0, 1'b1);
		send_cell(16'h0401, 12'd11, 1'b0, 1'b1, 1'b0);
		send_cell(16'h8000, 12'd12, 1'b0, 1'b0, 1'b0);
		send_cell(16'h8800, 12'd13, 1'b0, 1'b1, 1'b0);
		// Two forced cells are left in an open window; rewriting the register
		// empties it, so the next two cells do not complete a window.
		set_max_run(7'd2);
		send_cell(16'h8000, 12'd20, 1'b0, 1'b0, 1'b1);
		send_cell(16'h8000, 12'd21, 1'b0, 1'b0, 1'b0);
		set_max_run(7'd2);
		send_cell(16'h8000, 12'd22, 1'b0, 1'b0, 1'b0);
		send_cell(16'h4000, 12'd23, 1'b0, 1'b1, 1'b0);
		// Above the ring depth acts as 64: one flexible cell in 65 gives a ban.
		set_max_run(7'd127);
		for (int k = 0; k < 65; k++) begin
			send_cell((k == 30) ? 16'hCC10 : 16'h8400, 12'(400 + k), 1'b0, k == 64, k == 0);
		end
		tx_idle_on = 1'b0;
		// At exactly 64, a full column line of forced cells contradicts.
		set_max_run(7'd64);
		for (int k = 0; k < 66; k++) begin
			send_cell(16'hA000, 12'(4000 + k), 1'b1, k == 65, k == 0);
		end
		wait_for_results();
	endtask

	// The sink holds off for a long stretch while the sender keeps offering
	// cells that each cause a ban, so the block has to stall its input.
	task automatic test_backpressure();
		set_max_run(7'd1);
		tx_idle_on  = 1'b0;
		rx_idle_on  = 1'b0;
		rx_hold_len = 300;
		rx_holds_asked++;
		for (int k = 0; k < 40; k++) begin
			send_cell((k % 2 == 1) ? 16'hCC01 : 16'h8400, 12'(k), 1'b0, k == 39, k == 0);
		end
		wait_for_results();
		rx_idle_on = 1'b1;
		rx_hold_len = 120;
		rx_holds_asked++;
		for (int k = 0; k < 20; k++) begin
			send_cell((k % 2 == 0) ? 16'hA0A2 : 16'h0020, 12'(2000 + k), 1'b1, k == 19, k == 0);
		end
		wait_for_results();
	endtask

	// Most register settings are small; the extremes come up now and then.
	function automatic logic [RUN_BITS-1:0] pick_run_setting();
		unique case ($urandom_range(0, 19))
			0:       return 7'd0;
			1:       return 7'd64;
			2:       return RUN_BITS'($urandom_range(65, 127));
			3:       return RUN_BITS'($urandom_range(9, 63));
			default: return RUN_BITS'($urandom_range(1, 8));
		endcase
	endfunction

	// Phases of passes made of well-formed lines with random content, mixed
	// with noise and lines left open. Each phase has its own register value
	// and idling pattern.
	task automatic test_random_lines();
		int                  goal;
		int                  phase_goal;
		int                  run;
		int                  n_lines;
		int                  len;
		int                  pct_forced;
		int                  pct_flex;
		logic [RUN_BITS-1:0] setting;
		goal = n_cells + RANDOM_CELLS;
		while (n_cells < goal) begin
			setting = pick_run_setting();
			set_max_run(setting);
			run        = effective_run(setting);
			tx_idle_on = $urandom_range(0, 2) != 0;
			rx_idle_on = $urandom_range(0, 2) != 0;
			phase_goal = n_cells + ((run > 16) ? 2 * run + 10 : 60);
			while (n_cells < phase_goal && n_cells < goal) begin
				if ($urandom_range(0, 9) == 0) begin
					send_noise($urandom_range(1, 6));
				end else begin
					n_lines = $urandom_range(1, 4);
					for (int l = 0; l < n_lines; l++) begin
						len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, run)
							: $urandom_range(run + 1, run + 6);
						// Long windows only produce results when nearly all
						// cells are forced.
						pct_forced = (run > 16) ? 97 : $urandom_range(50, 95);
						pct_flex   = (run > 16) ? 3 : (100 - pct_forced) * 2 / 3;
						send_line(len, l == 0, $urandom_range(0, 9) != 0, pct_forced, pct_flex);
					end
				end
			end
		end
		wait_for_results();
	endtask

	// ------------------------------------------------------------------------
	// Sequence and end of run.
	// ------------------------------------------------------------------------
	initial begin : test_sequence
		int c;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_register_extremes();
		test_backpressure();
		test_random_lines();
		s_tvalid <= 1'b0;
		for (c = 0; c < 2000 && pending_results.size() != 0; c++) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			report_failure($sformatf("%0d results never arrived", pending_results.size()));
		end
		if (n_fail == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin : watchdog
		#TIMEOUT_NS;
		$display("Mismatches found");
		$finish;
	end

endmodule

/* files.f */
src/mrw_pkg.sv
src/mrw_cell.sv
src/mrw_out_fifo.sv
src/max_run_window_ban_checker.sv
bench/max_run_window_ban_checker_tb.sv
